// ----- hdl/met_pkg.sv -----
// ----------------------------------------------------------------------------
// met_pkg: shared types and constants of the expression tokenizer
// Holds the buffer depths, the derived widths, the character codes, the
// token kind codes and the structs that pass between the sequencer and the
// token buffers.
// ----------------------------------------------------------------------------
`default_nettype none

package met_pkg;

   localparam int NUMBER_DEPTH = 16;
   localparam int LETTER_DEPTH = 8;
   localparam int MAX_RESULTS  = 32;

   localparam int NUM_CW = $clog2(NUMBER_DEPTH + 1);
   localparam int LET_CW = $clog2(LETTER_DEPTH + 1);
   localparam int NUM_AW = (NUMBER_DEPTH > 1) ? $clog2(NUMBER_DEPTH) : 1;
   localparam int LET_AW = (LETTER_DEPTH > 1) ? $clog2(LETTER_DEPTH) : 1;
   localparam int IDX_W  = (NUM_CW > LET_CW) ? NUM_CW : LET_CW;
   localparam int RES_CW = $clog2(MAX_RESULTS + 1);

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;

   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_END  = 1'b1;

   typedef enum logic [2:0] {
      TK_LIT = 3'd0,
      TK_VAR = 3'd1,
      TK_OP  = 3'd2,
      TK_FUN = 3'd3,
      TK_LP  = 3'd4,
      TK_RP  = 3'd5,
      TK_SEP = 3'd6
   } token_kind_type;

   // Buffer update applied when a transaction finishes.
   typedef struct packed {
      logic       clr_num;
      logic       clr_let;
      logic       app_num;
      logic       app_let;
      logic [7:0] ch;
   } commit_type;

   typedef struct packed {
      logic [NUM_CW-1:0] num_count;
      logic              num_ovf;
      logic [LET_CW-1:0] let_count;
      logic              let_ovf;
   } buf_status_type;

endpackage

`default_nettype wire

// ----- hdl/met_buffers.sv -----
// ----------------------------------------------------------------------------
// met_buffers: literal and letter buffers
// Two small memories with fill counts and overflow flags. Reads are
// registered; writes and clears come in as one commit per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module met_buffers (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire met_pkg::commit_type        commit,
   input  wire logic [met_pkg::NUM_AW-1:0] num_addr,
   input  wire logic [met_pkg::LET_AW-1:0] let_addr,
   output met_pkg::buf_status_type         status,
   output logic [7:0]                      num_rd,
   output logic [7:0]                      let_rd
);

   logic [7:0] num_store [met_pkg::NUMBER_DEPTH];
   logic [7:0] let_store [met_pkg::LETTER_DEPTH];

   logic [met_pkg::NUM_CW-1:0] num_count_ff, num_count_in;
   logic [met_pkg::LET_CW-1:0] let_count_ff, let_count_in;
   logic                       num_ovf_ff, num_ovf_in;
   logic                       let_ovf_ff, let_ovf_in;
   logic [7:0]                 num_rd_ff, let_rd_ff;
   logic                       num_full, let_full;

   assign num_full = (num_count_ff == met_pkg::NUM_CW'(met_pkg::NUMBER_DEPTH));
   assign let_full = (let_count_ff == met_pkg::LET_CW'(met_pkg::LETTER_DEPTH));

   always_comb begin
      num_count_in = num_count_ff;
      num_ovf_in   = num_ovf_ff;
      let_count_in = let_count_ff;
      let_ovf_in   = let_ovf_ff;
      if (commit.clr_num) begin
         num_count_in = '0;
         num_ovf_in   = 1'b0;
      end else if (commit.app_num) begin
         if (num_full) begin
            num_ovf_in = 1'b1;
         end else begin
            num_count_in = num_count_ff + 1'b1;
         end
      end
      if (commit.clr_let) begin
         let_count_in = '0;
         let_ovf_in   = 1'b0;
      end else if (commit.app_let) begin
         if (let_full) begin
            let_ovf_in = 1'b1;
         end else begin
            let_count_in = let_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_count_ff <= '0;
         num_ovf_ff   <= 1'b0;
         let_count_ff <= '0;
         let_ovf_ff   <= 1'b0;
      end else begin
         num_count_ff <= num_count_in;
         num_ovf_ff   <= num_ovf_in;
         let_count_ff <= let_count_in;
         let_ovf_ff   <= let_ovf_in;
      end
   end

   // Store and read ports; no reset on payload.
   always_ff @(posedge clock) begin
      if (commit.app_num && !num_full) begin
         num_store[num_count_ff[met_pkg::NUM_AW-1:0]] <= commit.ch;
      end
      if (commit.app_let && !let_full) begin
         let_store[let_count_ff[met_pkg::LET_AW-1:0]] <= commit.ch;
      end
      num_rd_ff <= num_store[num_addr];
      let_rd_ff <= let_store[let_addr];
   end

   assign status.num_count = num_count_ff;
   assign status.num_ovf   = num_ovf_ff;
   assign status.let_count = let_count_ff;
   assign status.let_ovf   = let_ovf_ff;
   assign num_rd           = num_rd_ff;
   assign let_rd           = let_rd_ff;

endmodule

`default_nettype wire

// ----- hdl/math_expression_tokenizer.sv -----
// ----------------------------------------------------------------------------
// math_expression_tokenizer: arithmetic expression tokenizer
// Takes one ASCII character per transaction and emits tokens one text
// character per result, with implied multiplication after literals and
// between single-letter variables.
// ----------------------------------------------------------------------------
//
//   channel  dir  tdata                        tuser           tlast
//   req_     in   char_code[7:0]               kind (1 = end)  -
//   rsp_     out  token_char[7:0], text_last,  token_kind[2:0] run_last
//                 truncated, zero fill to 16
//
// A character that only buffers (digit, dot, letter with no pending
// literal) or is skipped leaves req_tready high. A flushing character is
// accepted and its results come out of the sequencer one per cycle while
// rsp_tready allows, through a single result register; at most MAX_RESULTS
// results per transaction.
// Reset is synchronous and empties both buffers; no clearing pass is needed.
// A stall on rsp_tready freezes the sequencer; req_tready stays low until the
// last result of a transaction is loaded into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module math_expression_tokenizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tuser,   // [0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] token_char, [8] text_last,
                                         // [9] truncated, [15:10] zero
   output logic [2:0]       rsp_tuser,   // [2:0] token_kind
   output logic             rsp_tlast    // run_last
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_LIT,
      PH_VAR,
      PH_FUN,
      PH_STAR,
      PH_TOK
   } phase_type;

   // Phases still to run in the current transaction.
   typedef struct packed {
      logic lit;
      logic vars;
      logic fun;
      logic star;
      logic tok;
   } pend_type;

   // Pick the next phase: literal and letters in the order the character
   // asks for, then function name, implied '*', and the character's token.
   function automatic phase_type first_phase(pend_type p, logic var_first);
      phase_type ph;
      ph = PH_TOK;
      priority if (var_first && p.vars) begin
         ph = PH_VAR;
      end else if (p.lit) begin
         ph = PH_LIT;
      end else if (p.vars) begin
         ph = PH_VAR;
      end else if (p.fun) begin
         ph = PH_FUN;
      end else if (p.star) begin
         ph = PH_STAR;
      end else begin
         ph = PH_TOK;
      end
      return ph;
   endfunction

   state_type                   state_ff, state_in;
   phase_type                   phase_ff, phase_in;
   pend_type                    pend_ff, pend_in;
   logic [met_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic                        star_ff, star_in;
   logic                        var_first_ff, var_first_in;
   logic [met_pkg::RES_CW-1:0]  res_cnt_ff, res_cnt_in;
   met_pkg::commit_type         plan_ff, plan_in;
   met_pkg::token_kind_type     tok_kind_ff, tok_kind_in;
   logic [7:0]                  tok_char_ff, tok_char_in;

   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]                  rsp_char_ff, rsp_char_in;
   logic                        rsp_text_last_ff, rsp_text_last_in;
   logic                        rsp_trunc_ff, rsp_trunc_in;
   met_pkg::token_kind_type     rsp_kind_ff, rsp_kind_in;
   logic                        rsp_run_last_ff, rsp_run_last_in;

   met_pkg::commit_type         commit;
   met_pkg::buf_status_type     status;
   logic [7:0]                  num_rd, let_rd;

   logic                        accept, out_free;
   logic                        is_end, is_digit, is_letter, is_op, is_lp, is_rp, is_sep;
   logic                        has_num, has_let;
   pend_type                    dec_pend, pend_after;
   met_pkg::commit_type         dec_commit;
   met_pkg::token_kind_type     dec_kind;

   met_pkg::token_kind_type     e_kind;
   logic [7:0]                  e_char;
   logic                        e_last, e_trunc, step_done, final_res;
   logic                        last_lit, last_let;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign has_num = (status.num_count != '0);
   assign has_let = (status.let_count != '0);

   // Classify the incoming character.
   always_comb begin
      is_end    = (req_tuser == met_pkg::REQ_END);
      is_digit  = !is_end && (((req_tdata >= met_pkg::CH_0) && (req_tdata <= met_pkg::CH_9))
                              || (req_tdata == met_pkg::CH_DOT));
      is_letter = !is_end && (((req_tdata >= met_pkg::CH_UA) && (req_tdata <= met_pkg::CH_UZ))
                              || ((req_tdata >= met_pkg::CH_LA) && (req_tdata <= met_pkg::CH_LZ)));
      is_op     = !is_end && ((req_tdata == met_pkg::CH_PLUS) || (req_tdata == met_pkg::CH_MINUS)
                              || (req_tdata == met_pkg::CH_STAR)
                              || (req_tdata == met_pkg::CH_SLASH));
      is_lp     = !is_end && (req_tdata == met_pkg::CH_LPAR);
      is_rp     = !is_end && (req_tdata == met_pkg::CH_RPAR);
      is_sep    = !is_end && (req_tdata == met_pkg::CH_COMMA);

      dec_pend.lit  = has_num && (is_end || is_op || is_rp || is_sep || is_letter
                                  || (is_lp && !has_let));
      dec_pend.vars = has_let && (is_end || is_op || is_rp || is_sep);
      dec_pend.fun  = has_let && is_lp;
      dec_pend.star = has_num && (is_letter || (is_lp && !has_let));
      dec_pend.tok  = is_op || is_lp || is_rp || is_sep;

      dec_commit.clr_num = dec_pend.lit;
      dec_commit.clr_let = dec_pend.vars || dec_pend.fun;
      dec_commit.app_num = is_digit;
      dec_commit.app_let = is_letter;
      dec_commit.ch      = req_tdata;

      priority if (is_lp) begin
         dec_kind = met_pkg::TK_LP;
      end else if (is_rp) begin
         dec_kind = met_pkg::TK_RP;
      end else if (is_sep) begin
         dec_kind = met_pkg::TK_SEP;
      end else begin
         dec_kind = met_pkg::TK_OP;
      end
   end

   // One result from the current phase.
   always_comb begin
      last_lit   = ((idx_ff + 1'b1) == met_pkg::IDX_W'(status.num_count));
      last_let   = ((idx_ff + 1'b1) == met_pkg::IDX_W'(status.let_count));
      e_kind     = met_pkg::TK_OP;
      e_char     = met_pkg::CH_STAR;
      e_last     = 1'b1;
      e_trunc    = 1'b0;
      step_done  = 1'b0;
      pend_after = pend_ff;
      unique case (phase_ff)
         PH_LIT: begin
            e_kind          = met_pkg::TK_LIT;
            e_char          = num_rd;
            e_last          = last_lit;
            e_trunc         = status.num_ovf;
            step_done       = last_lit;
            pend_after.lit  = 1'b0;
         end
         PH_VAR: begin
            if (!star_ff) begin
               e_kind  = met_pkg::TK_VAR;
               e_char  = let_rd;
               e_trunc = status.let_ovf;
            end
            step_done       = !star_ff && last_let;
            pend_after.vars = 1'b0;
         end
         PH_FUN: begin
            e_kind         = met_pkg::TK_FUN;
            e_char         = let_rd;
            e_last         = last_let;
            e_trunc        = status.let_ovf;
            step_done      = last_let;
            pend_after.fun = 1'b0;
         end
         PH_STAR: begin
            step_done       = 1'b1;
            pend_after.star = 1'b0;
         end
         PH_TOK: begin
            e_kind         = tok_kind_ff;
            e_char         = tok_char_ff;
            step_done      = 1'b1;
            pend_after.tok = 1'b0;
         end
         default: begin
            step_done = 1'b1;
         end
      endcase
      final_res = (step_done && (pend_after == '0))
                  || (res_cnt_ff == met_pkg::RES_CW'(met_pkg::MAX_RESULTS - 1));
   end

   // Sequencer next state.
   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      pend_in          = pend_ff;
      idx_in           = idx_ff;
      star_in          = star_ff;
      var_first_in     = var_first_ff;
      res_cnt_in       = res_cnt_ff;
      plan_in          = plan_ff;
      tok_kind_in      = tok_kind_ff;
      tok_char_in      = tok_char_ff;
      commit           = '0;
      rsp_tvalid_in    = rsp_tvalid_ff && !rsp_tready;
      rsp_char_in      = rsp_char_ff;
      rsp_text_last_in = rsp_text_last_ff;
      rsp_trunc_in     = rsp_trunc_ff;
      rsp_kind_in      = rsp_kind_ff;
      rsp_run_last_in  = rsp_run_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept) begin
               if (dec_pend != '0) begin
                  // Flush needed: hold the plan until the last result.
                  state_in     = ST_EMIT;
                  phase_in     = first_phase(dec_pend, is_rp);
                  pend_in      = dec_pend;
                  star_in      = 1'b0;
                  var_first_in = is_rp;
                  res_cnt_in   = '0;
                  plan_in      = dec_commit;
                  tok_kind_in  = dec_kind;
                  tok_char_in  = req_tdata;
               end else begin
                  commit = dec_commit;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in    = 1'b1;
               rsp_char_in      = e_char;
               rsp_text_last_in = e_last;
               rsp_trunc_in     = e_trunc;
               rsp_kind_in      = e_kind;
               rsp_run_last_in  = final_res;
               res_cnt_in       = res_cnt_ff + 1'b1;
               if (final_res) begin
                  commit   = plan_ff;
                  state_in = ST_IDLE;
                  idx_in   = '0;
               end else if (step_done) begin
                  pend_in  = pend_after;
                  phase_in = first_phase(pend_after, var_first_ff);
                  idx_in   = '0;
                  star_in  = 1'b0;
               end else if (phase_ff == PH_VAR) begin
                  // Alternate letter and implied '*'; advance after the '*'.
                  star_in = !star_ff;
                  if (star_ff) begin
                     idx_in = idx_ff + 1'b1;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_TOK;
         pend_ff       <= '0;
         idx_ff        <= '0;
         star_ff       <= 1'b0;
         var_first_ff  <= 1'b0;
         res_cnt_ff    <= '0;
         plan_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         pend_ff       <= pend_in;
         idx_ff        <= idx_in;
         star_ff       <= star_in;
         var_first_ff  <= var_first_in;
         res_cnt_ff    <= res_cnt_in;
         plan_ff       <= plan_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      tok_kind_ff      <= tok_kind_in;
      tok_char_ff      <= tok_char_in;
      rsp_char_ff      <= rsp_char_in;
      rsp_text_last_ff <= rsp_text_last_in;
      rsp_trunc_ff     <= rsp_trunc_in;
      rsp_kind_ff      <= rsp_kind_in;
      rsp_run_last_ff  <= rsp_run_last_in;
   end

   // Buffers read one index ahead, so the data for idx_ff is ready each cycle.
   met_buffers u_buffers (
      .clock    (clock),
      .reset    (reset),
      .commit   (commit),
      .num_addr (idx_in[met_pkg::NUM_AW-1:0]),
      .let_addr (idx_in[met_pkg::LET_AW-1:0]),
      .status   (status),
      .num_rd   (num_rd),
      .let_rd   (let_rd)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'b0, rsp_trunc_ff, rsp_text_last_ff, rsp_char_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_run_last_ff;

endmodule

`default_nettype wire

// ----- hdl/met_port_check.sv -----
// ----------------------------------------------------------------------------
// met_port_check: port-level checks for the expression tokenizer
// Watches the top-level channels and flags behavior that the tokenizer
// must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module met_port_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // Empty result channel right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // An operator always yields a result, so the input side must close.
   a_op_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == met_pkg::REQ_CHAR)
      && ((req_tdata == met_pkg::CH_PLUS) || (req_tdata == met_pkg::CH_MINUS)
          || (req_tdata == met_pkg::CH_STAR) || (req_tdata == met_pkg::CH_SLASH))
      |=> !req_tready)
      else $error("operator accepted without starting a flush");

   // A digit only buffers and never stalls the input side.
   a_digit_free: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == met_pkg::REQ_CHAR)
      && (req_tdata >= met_pkg::CH_0) && (req_tdata <= met_pkg::CH_9)
      |=> req_tready)
      else $error("digit caused a flush");

   // Single-character tokens are whole and never truncated.
   a_single_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != met_pkg::TK_LIT) && (rsp_tuser != met_pkg::TK_VAR)
      && (rsp_tuser != met_pkg::TK_FUN)
      |-> rsp_tdata[8] && !rsp_tdata[9] && (rsp_tuser != 3'd7))
      else $error("bad single-character token");

endmodule

bind math_expression_tokenizer met_port_check u_port_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ----- verif/met_token_checker.sv -----
// ----------------------------------------------------------------------------
// met_token_checker: token predictor and result checker for the tokenizer
// Watches the request and response channels, predicts the token stream for
// every accepted character and compares each response field by field with
// the oldest predicted token.
// ----------------------------------------------------------------------------

module met_token_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tuser,   // [0] kind
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,   // [7:0] token_char, [8] text_last,
                                         // [9] truncated, [15:10] zero
   input  wire logic [2:0]  rsp_tuser,   // [2:0] token_kind
   input  wire logic        rsp_tlast,   // run_last
   output int               mismatch_count,
   output int               pending_tokens
);

   typedef struct {
      met_pkg::token_kind_type kind;
      logic [7:0]              text_char;
      logic                    text_last;
      logic                    truncated;
      logic                    run_last;
   } token_result_type;

   // Mirror of the block's literal and letter buffers.
   logic [7:0]    num_text [met_pkg::NUMBER_DEPTH];
   int            num_len;
   logic          num_trunc;
   logic [7:0]    let_text [met_pkg::LETTER_DEPTH];
   int            let_len;
   logic          let_trunc;

   token_result_type step_tokens[$];
   token_result_type expected_tokens[$];
   int               errors = 0;

   function automatic logic is_number_char(input logic [7:0] c);
      return (c >= met_pkg::CH_0 && c <= met_pkg::CH_9) || c == met_pkg::CH_DOT;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= met_pkg::CH_UA && c <= met_pkg::CH_UZ)
             || (c >= met_pkg::CH_LA && c <= met_pkg::CH_LZ);
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return c == met_pkg::CH_PLUS || c == met_pkg::CH_MINUS
             || c == met_pkg::CH_STAR || c == met_pkg::CH_SLASH;
   endfunction

   task automatic push_token(input met_pkg::token_kind_type kind, input logic [7:0] ch,
                             input logic last, input logic trunc);
      token_result_type tok;
      if (step_tokens.size() < met_pkg::MAX_RESULTS) begin
         tok.kind      = kind;
         tok.text_char = ch;
         tok.text_last = last;
         tok.truncated = trunc;
         tok.run_last  = 1'b0;
         step_tokens.push_back(tok);
      end
   endtask

   task automatic flush_number();
      int i;
      for (i = 0; i < num_len; i++)
         push_token(met_pkg::TK_LIT, num_text[i], i + 1 == num_len, num_trunc);
      num_len   = 0;
      num_trunc = 1'b0;
   endtask

   // Each letter is its own variable, joined by an implied '*'.
   task automatic flush_variables();
      int i;
      for (i = 0; i < let_len; i++) begin
         push_token(met_pkg::TK_VAR, let_text[i], 1'b1, let_trunc);
         if (i + 1 < let_len)
            push_token(met_pkg::TK_OP, met_pkg::CH_STAR, 1'b1, 1'b0);
      end
      let_len   = 0;
      let_trunc = 1'b0;
   endtask

   task automatic flush_function();
      int i;
      for (i = 0; i < let_len; i++)
         push_token(met_pkg::TK_FUN, let_text[i], i + 1 == let_len, let_trunc);
      let_len   = 0;
      let_trunc = 1'b0;
   endtask

   task automatic tokenize_char(input logic item_kind, input logic [7:0] c);
      step_tokens.delete();
      if (item_kind == met_pkg::REQ_END) begin
         flush_number();
         flush_variables();
      end else if (is_number_char(c)) begin
         if (num_len < met_pkg::NUMBER_DEPTH) begin
            num_text[num_len] = c;
            num_len++;
         end else begin
            num_trunc = 1'b1;
         end
      end else if (is_letter(c)) begin
         if (num_len != 0) begin
            flush_number();
            push_token(met_pkg::TK_OP, met_pkg::CH_STAR, 1'b1, 1'b0);
         end
         if (let_len < met_pkg::LETTER_DEPTH) begin
            let_text[let_len] = c;
            let_len++;
         end else begin
            let_trunc = 1'b1;
         end
      end else if (is_operator(c)) begin
         flush_number();
         flush_variables();
         push_token(met_pkg::TK_OP, c, 1'b1, 1'b0);
      end else if (c == met_pkg::CH_LPAR) begin
         // letters win: a buffered literal stays put
         if (let_len != 0) begin
            flush_function();
         end else if (num_len != 0) begin
            flush_number();
            push_token(met_pkg::TK_OP, met_pkg::CH_STAR, 1'b1, 1'b0);
         end
         push_token(met_pkg::TK_LP, c, 1'b1, 1'b0);
      end else if (c == met_pkg::CH_RPAR) begin
         flush_variables();
         flush_number();
         push_token(met_pkg::TK_RP, c, 1'b1, 1'b0);
      end else if (c == met_pkg::CH_COMMA) begin
         flush_number();
         flush_variables();
         push_token(met_pkg::TK_SEP, c, 1'b1, 1'b0);
      end
      if (step_tokens.size() > 0)
         step_tokens[step_tokens.size() - 1].run_last = 1'b1;
      foreach (step_tokens[i])
         expected_tokens.push_back(step_tokens[i]);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      token_result_type want;
      if (reset) begin
         num_len   = 0;
         num_trunc = 1'b0;
         let_len   = 0;
         let_trunc = 1'b0;
         expected_tokens.delete();
      end else begin
         // predict first: a response never belongs to the same-edge request
         if (req_tvalid && req_tready)
            tokenize_char(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               $error("unexpected result: token_kind %0h token_char %0h run_last %0b",
                      rsp_tuser, rsp_tdata[7:0], rsp_tlast);
               errors++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("token_kind", {5'd0, want.kind}, {5'd0, rsp_tuser});
               check_field("token_char", want.text_char, rsp_tdata[7:0]);
               check_field("text_last", {7'd0, want.text_last}, {7'd0, rsp_tdata[8]});
               check_field("truncated", {7'd0, want.truncated}, {7'd0, rsp_tdata[9]});
               check_field("run_last", {7'd0, want.run_last}, {7'd0, rsp_tlast});
               check_field("tdata fill", 8'd0, {2'd0, rsp_tdata[15:10]});
            end
         end
      end
      mismatch_count <= errors;
      pending_tokens <= expected_tokens.size();
   end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: top level of the expression tokenizer testbench
// Drives characters of arithmetic expressions into the tokenizer: a short
// directed sweep, long runs that overflow both buffers, then random
// expression fragments in bursts, while the response side stalls on its own
// pattern. A checker module predicts and compares every token; this module
// makes stimulus, runs a watchdog and gives the verdict.
// ----------------------------------------------------------------------------

module tb;

   localparam int CLOCK_HALF       = 5;
   localparam int RESET_CYCLES     = 4;
   localparam int RANDOM_ITEMS     = 300;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int TAIL_CYCLES      = 40;

   // kinds of character runs
   localparam logic NUMBER_RUN = 1'b0;
   localparam logic LETTER_RUN = 1'b1;

   // response-side stall modes
   localparam int RX_OPEN   = 0;
   localparam int RX_RANDOM = 1;
   localparam int RX_SPARSE = 2;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   int mismatch_count;
   int pending_tokens;
   int burst_left    = 0;
   bit long_hold_req = 1'b0;

   math_expression_tokenizer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   met_token_checker i_token_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .pending_tokens (pending_tokens)
   );

   initial clock = 1'b0;
   always #(CLOCK_HALF) clock = ~clock;

   // Offer one transaction and hold it until it is accepted. The sender works
   // in bursts; at the start of each burst drop valid for a random gap (or
   // none). Call and return on a rising edge.
   task automatic send_item(input logic item_kind, input logic [7:0] code);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= item_kind;
      req_tdata  <= code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_text(input string text);
      int i;
      for (i = 0; i < text.len(); i++)
         send_item(met_pkg::REQ_CHAR, text[i]);
   endtask

   function automatic logic [7:0] pick_number_char();
      if ($urandom_range(0, 5) == 0)
         return met_pkg::CH_DOT;
      return met_pkg::CH_0 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] pick_letter();
      if ($urandom_range(0, 1) == 0)
         return met_pkg::CH_UA + 8'($urandom_range(0, 25));
      return met_pkg::CH_LA + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(0, 3))
         0: return met_pkg::CH_PLUS;
         1: return met_pkg::CH_MINUS;
         2: return met_pkg::CH_STAR;
         default: return met_pkg::CH_SLASH;
      endcase
   endfunction

   // Whitespace and control codes, high codes, or any code at random.
   function automatic logic [7:0] pick_noise();
      case ($urandom_range(0, 3))
         0: return 8'h20;
         1: return 8'h09;
         2: return 8'($urandom_range(128, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_run(input logic run_kind, input int len);
      int i;
      for (i = 0; i < len; i++)
         send_item(met_pkg::REQ_CHAR,
                   run_kind == LETTER_RUN ? pick_letter() : pick_number_char());
   endtask

   // Drop valid and hold off until the checker has seen every predicted token.
   task automatic wait_all_tokens();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_tokens != 0) @(posedge clock);
   endtask

   // Response side: alternate open, random and sparse stretches; on request
   // hold tready low for a long stretch so the block backs up its input.
   initial begin : rx_pattern
      int seg_left;
      int seg_mode;
      seg_left   = 0;
      seg_mode   = RX_OPEN;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         if (seg_left == 0) begin
            seg_mode = $urandom_range(RX_OPEN, RX_SPARSE);
            seg_left = $urandom_range(4, 40);
         end
         seg_left--;
         case (seg_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
            default:   rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Watchdog: end the run once no transaction moves on either channel for
   // too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int  payload_items;
      int  choice;
      int  len;
      bit  hold_done;
      bit  drain_done;
      payload_items = 0;
      hold_done     = 1'b0;
      drain_done    = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'd0;
      req_tuser  = met_pkg::REQ_CHAR;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed sweep: literal then implied '*', function after letters,
      // '(' after a literal, letters over a buffered literal at '(' and ')',
      // every operator, separator, skipped codes, end with and without
      // buffered text.
      send_item(met_pkg::REQ_END, 8'h00);
      send_text("1.5a(Z)+9xy-3(x2(a7)*/,");
      send_item(met_pkg::REQ_CHAR, 8'h80);
      send_item(met_pkg::REQ_CHAR, 8'hFF);
      send_text(" .");
      send_item(met_pkg::REQ_END, 8'hA5);

      // Buffer overflow: truncated literal, function and variables, and a
      // truncated literal ahead of an implied '*'.
      send_run(NUMBER_RUN, met_pkg::NUMBER_DEPTH + 4);
      send_item(met_pkg::REQ_CHAR, met_pkg::CH_PLUS);
      send_run(LETTER_RUN, met_pkg::LETTER_DEPTH + 3);
      send_item(met_pkg::REQ_CHAR, met_pkg::CH_LPAR);
      send_run(LETTER_RUN, met_pkg::LETTER_DEPTH + 2);
      send_item(met_pkg::REQ_CHAR, met_pkg::CH_COMMA);
      send_run(NUMBER_RUN, met_pkg::NUMBER_DEPTH + 1);
      send_run(LETTER_RUN, met_pkg::LETTER_DEPTH + 1);
      send_item(met_pkg::REQ_CHAR, met_pkg::CH_RPAR);
      send_item(met_pkg::REQ_END, 8'h5A);

      // Random expression fragments. Skipped characters are not counted.
      while (payload_items < RANDOM_ITEMS) begin
         choice = $urandom_range(0, 99);
         if (choice < 25) begin
            len = ($urandom_range(0, 15) == 0)
                  ? $urandom_range(met_pkg::NUMBER_DEPTH - 1, met_pkg::NUMBER_DEPTH + 4)
                  : $urandom_range(1, 4);
            send_run(NUMBER_RUN, len);
            payload_items += len;
         end else if (choice < 45) begin
            len = ($urandom_range(0, 10) == 0)
                  ? $urandom_range(met_pkg::LETTER_DEPTH - 1, met_pkg::LETTER_DEPTH + 4)
                  : $urandom_range(1, 3);
            send_run(LETTER_RUN, len);
            payload_items += len;
         end else if (choice < 60) begin
            send_item(met_pkg::REQ_CHAR, pick_operator());
            payload_items++;
         end else if (choice < 70) begin
            // half the time a function call head, else a bare '('
            if ($urandom_range(0, 1) == 0) begin
               len = $urandom_range(1, 4);
               send_run(LETTER_RUN, len);
               payload_items += len;
            end
            send_item(met_pkg::REQ_CHAR, met_pkg::CH_LPAR);
            payload_items++;
         end else if (choice < 78) begin
            send_item(met_pkg::REQ_CHAR, met_pkg::CH_RPAR);
            payload_items++;
         end else if (choice < 83) begin
            send_item(met_pkg::REQ_CHAR, met_pkg::CH_COMMA);
            payload_items++;
         end else if (choice < 89) begin
            send_item(met_pkg::REQ_END, 8'($urandom_range(0, 255)));
            payload_items++;
         end else begin
            send_item(met_pkg::REQ_CHAR, pick_noise());
         end

         // Back up the block once with a long response hold-off, and once
         // let everything drain before going on.
         if (!hold_done && payload_items >= RANDOM_ITEMS / 4) begin
            long_hold_req = 1'b1;
            hold_done     = 1'b1;
         end
         if (!drain_done && payload_items >= (RANDOM_ITEMS * 2) / 3) begin
            wait_all_tokens();
            drain_done = 1'b1;
         end
      end

      // Flush whatever is still buffered, then drain and let the block settle.
      send_item(met_pkg::REQ_END, 8'($urandom_range(0, 255)));
      wait_all_tokens();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_tokens == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/met_pkg.sv
hdl/met_buffers.sv
hdl/math_expression_tokenizer.sv
hdl/met_port_check.sv
verif/met_token_checker.sv
verif/tb.sv
